// ===== design/sorted_timer_expiry_queue_macros.svh =====
// Assertion macros for the sorted timer expiry queue.
`ifndef SORTED_TIMER_EXPIRY_QUEUE_MACROS_SVH
`define SORTED_TIMER_EXPIRY_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
`define STEQ_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("sorted timer queue check failed");
`define STEQ_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("sorted timer queue check failed");
`else
`define STEQ_ASSERT_NOW(lbl, ck, rn, ante, cons)
`define STEQ_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

// ===== design/steq_pkg.sv =====
// Shared types and constants for the sorted timer expiry queue.
package steq_pkg;

	localparam int ID_W          = 4;
	localparam int TIME_W        = 64;
	localparam int MAX_TIMERS_DEF = 16;
	localparam int TIME_BITS_DEF  = 64;

	typedef enum logic [1:0] {
		OP_ADD  = 2'd0,
		OP_DEL  = 2'd1,
		OP_TICK = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		KIND_ADDED    = 3'd0,
		KIND_DELETED  = 3'd1,
		KIND_EXPIRED  = 3'd2,
		KIND_NONE_DUE = 3'd3,
		KIND_FULL     = 3'd4,
		KIND_NOT_FOUND = 3'd5,
		KIND_DUPLICATE = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ADD,
		ST_DEL,
		ST_TICK
	} state_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_ADD,
		CELL_DEL,
		CELL_POP
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t         cmd;
		logic [ID_W-1:0]   key_id;
	} cell_ctl_t;

	typedef struct packed {
		logic              valid;
		logic [ID_W-1:0]   handle;
	} entry_t;

	typedef struct packed {
		logic [1:0]        operation;
		logic [ID_W-1:0]   timer_id;
		logic [TIME_W-1:0] expire_time;
		logic [TIME_W-1:0] current_time;
	} req_t;

	typedef struct packed {
		logic [2:0]        kind;
		logic [ID_W-1:0]   fired_id;
		logic [TIME_W-1:0] fired_time;
		logic              last;
	} rsp_t;

endpackage

// ===== design/sorted_timer_expiry_queue.sv =====
// Add and delete: the request beat moves the sequencer to ST_ADD or ST_DEL, which loads
// the response register; the next request is taken once the sequencer is back in ST_IDLE.
// Tick: one response beat per cycle for each due timer (or one none-due beat), set by
// the due compares on the head slot and on slot 1 of the cell chain.
// Rates assume rsp_stall low; a stalled response holds the sequencer in place.
// Reset clears every slot valid bit, so the queue comes up empty; no clearing pass.
`include "sorted_timer_expiry_queue_macros.svh"
module sorted_timer_expiry_queue import steq_pkg::*; #(
	parameter int MAX_TIMERS = MAX_TIMERS_DEF,
	parameter int TIME_BITS  = TIME_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	// Sequencer state and the operand of the request being worked on.
	state_t               state_q, state_d;
	logic [ID_W-1:0]      key_id_q;
	logic [TIME_BITS-1:0] key_time_q;

	// Response output register; it parts the queue from the consumer.
	logic rsp_valid_q;
	rsp_t rsp_q, rsp_d;
	logic rsp_load;
	logic out_free;

	// Cell chain wiring. Slot 0 is the head (earliest expiry).
	cell_ctl_t            ctl;
	entry_t               ent   [MAX_TIMERS];
	logic [TIME_BITS-1:0] exp_a [MAX_TIMERS];
	logic [MAX_TIMERS-1:0] vld, ge_v, match_v, chain_v;

	logic any_match, full, head_due, next_due;

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// Build the row of slots. Each slot sees its left and right neighbor; the ends
	// see an empty slot, so a pop or delete shifts an empty entry in at the tail.
	for (genvar i = 0; i < MAX_TIMERS; i++) begin : g_cell
		entry_t               l_ent, r_ent;
		logic [TIME_BITS-1:0] l_exp, r_exp;
		logic                 l_ge, c_in;

		if (i == 0) begin : g_head
			assign l_ent = '0;
			assign l_exp = '0;
			assign l_ge  = 1'b0;
			assign c_in  = 1'b0;
		end else begin : g_mid
			assign l_ent = ent[i-1];
			assign l_exp = exp_a[i-1];
			assign l_ge  = ge_v[i-1];
			assign c_in  = chain_v[i-1];
		end

		if (i == MAX_TIMERS - 1) begin : g_tail
			assign r_ent = '0;
			assign r_exp = '0;
		end else begin : g_body
			assign r_ent = ent[i+1];
			assign r_exp = exp_a[i+1];
		end

		steq_cell #(
			.TIME_BITS (TIME_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.key_time  (key_time_q),
			.left_ent  (l_ent),
			.left_exp  (l_exp),
			.left_ge   (l_ge),
			.right_ent (r_ent),
			.right_exp (r_exp),
			.chain_in  (c_in),
			.ent       (ent[i]),
			.exp_out   (exp_a[i]),
			.ge        (ge_v[i]),
			.match     (match_v[i]),
			.chain_out (chain_v[i])
		);

		assign vld[i] = ent[i].valid;
	end

	// Valid bits fill from the head, so the tail slot tells whether the queue is full.
	assign any_match = |match_v;
	assign full      = vld[MAX_TIMERS-1];
	assign head_due  = vld[0] && (exp_a[0] <= key_time_q);
	assign next_due  = vld[1] && (exp_a[1] <= key_time_q);

	// Sequencer: take one request, then issue its response beats one per free cycle.
	always_comb begin
		state_d    = state_q;
		ctl.cmd    = CELL_HOLD;
		ctl.key_id = key_id_q;
		rsp_load   = 1'b0;
		rsp_d      = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					unique case (req.operation)
						OP_ADD:  state_d = ST_ADD;
						OP_DEL:  state_d = ST_DEL;
						OP_TICK: state_d = ST_TICK;
						default: state_d = ST_IDLE; // drop unused operation code
					endcase
				end
			end
			ST_ADD: begin
				if (out_free) begin
					rsp_load       = 1'b1;
					rsp_d.fired_id = key_id_q;
					rsp_d.last     = 1'b1;
					state_d        = ST_IDLE;
					// Duplicate check ranks ahead of the full check.
					if (any_match) begin
						rsp_d.kind = KIND_DUPLICATE;
					end else if (full) begin
						rsp_d.kind = KIND_FULL;
					end else begin
						rsp_d.kind = KIND_ADDED;
						ctl.cmd    = CELL_ADD;
					end
				end
			end
			ST_DEL: begin
				if (out_free) begin
					rsp_load       = 1'b1;
					rsp_d.fired_id = key_id_q;
					rsp_d.last     = 1'b1;
					state_d        = ST_IDLE;
					if (any_match) begin
						rsp_d.kind = KIND_DELETED;
						ctl.cmd    = CELL_DEL;
					end else begin
						rsp_d.kind = KIND_NOT_FOUND;
					end
				end
			end
			ST_TICK: begin
				if (out_free) begin
					rsp_load = 1'b1;
					if (head_due) begin
						// Pop the head; slot 1 becomes the head, so its compare says
						// whether this beat is the final one.
						rsp_d.kind       = KIND_EXPIRED;
						rsp_d.fired_id   = ent[0].handle;
						rsp_d.fired_time = TIME_W'(exp_a[0]);
						rsp_d.last       = !next_due;
						ctl.cmd          = CELL_POP;
						if (!next_due) begin
							state_d = ST_IDLE;
						end
					end else begin
						rsp_d.kind = KIND_NONE_DUE;
						rsp_d.last = 1'b1;
						state_d    = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Latch the operand on the request beat; a tick carries its time in current_time.
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			key_id_q <= req.timer_id;
			if (req.operation == OP_TICK) begin
				key_time_q <= req.current_time[TIME_BITS-1:0];
			end else begin
				key_time_q <= req.expire_time[TIME_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	// Occupied slots always form one run starting at the head.
	`STEQ_ASSERT_NOW(a_slots_packed, clk, arst_n, 1'b1, ((vld >> 1) & ~vld) == '0)
	// Only a tick produces beats that are not the final one of their request.
	`STEQ_ASSERT_NOW(a_nonlast_tick, clk, arst_n, rsp_valid_q && !rsp_q.last,
		rsp_q.kind == KIND_EXPIRED)
	// A successful add grows the queue by exactly one slot.
	`STEQ_ASSERT_NEXT(a_add_grows, clk, arst_n, ctl.cmd == CELL_ADD,
		$countones(vld) == $countones($past(vld)) + 1)

endmodule

// ===== design/steq_cell.sv =====
// One slot of the sorted queue: holds a timer and shifts with its neighbors.
module steq_cell import steq_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cell_ctl_t            ctl,
	input  logic [TIME_BITS-1:0] key_time,
	input  entry_t               left_ent,
	input  logic [TIME_BITS-1:0] left_exp,
	input  logic                 left_ge,
	input  entry_t               right_ent,
	input  logic [TIME_BITS-1:0] right_exp,
	input  logic                 chain_in,
	output entry_t               ent,
	output logic [TIME_BITS-1:0] exp_out,
	output logic                 ge,
	output logic                 match,
	output logic                 chain_out
);

	logic                 valid_q;
	logic [ID_W-1:0]      handle_q;
	logic [TIME_BITS-1:0] expiry_q;
	logic                 take_left, take_new, take_right;

	assign ent.valid  = valid_q;
	assign ent.handle = handle_q;
	assign exp_out    = expiry_q;

	// Slot is a candidate for the insert point when empty or not earlier than the key.
	assign ge        = !valid_q || (expiry_q >= key_time);
	assign match     = valid_q && (handle_q == ctl.key_id);
	assign chain_out = chain_in | match;

	always_comb begin
		take_left  = 1'b0;
		take_new   = 1'b0;
		take_right = 1'b0;
		unique case (ctl.cmd)
			CELL_HOLD: ;
			CELL_ADD: begin
				take_left = left_ge;
				take_new  = ge && !left_ge;
			end
			CELL_DEL: take_right = chain_out;
			CELL_POP: take_right = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_left) begin
			valid_q <= left_ent.valid;
		end else if (take_new) begin
			valid_q <= 1'b1;
		end else if (take_right) begin
			valid_q <= right_ent.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_left) begin
			handle_q <= left_ent.handle;
			expiry_q <= left_exp;
		end else if (take_new) begin
			handle_q <= ctl.key_id;
			expiry_q <= key_time;
		end else if (take_right) begin
			handle_q <= right_ent.handle;
			expiry_q <= right_exp;
		end
	end

endmodule
